// ===== design/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Depends on nothing; imported by every module of the block.
package deq_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 32;
	localparam int CMDQ_DEPTH   = 2;

	// action codes on the input channel
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_REAR   = 3'd3;
	localparam logic [2:0] ACT_DUMP       = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

// ===== design/deq_front.sv =====
// Front end: takes input transfers, decodes the action and drops unused codes.
// Depends on deq_pkg; feeds deq_cmdq.
module deq_front (
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        action,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              cmd_valid,
	output deq_pkg::cmd_t                     cmd,
	input  logic                              cmd_ready
);
	import deq_pkg::*;

	logic known;
	op_t  op;

	always_comb begin
		known = 1'b1;
		op    = OP_PUSH_FRONT;
		unique case (action)
			ACT_PUSH_FRONT: op = OP_PUSH_FRONT;
			ACT_PUSH_REAR:  op = OP_PUSH_REAR;
			ACT_POP_FRONT:  op = OP_POP_FRONT;
			ACT_POP_REAR:   op = OP_POP_REAR;
			ACT_DUMP:       op = OP_DUMP;
			default:        known = 1'b0;
		endcase
	end

	// unused codes are consumed here and never reach the back end
	assign in_stall  = !cmd_ready;
	assign cmd_valid = in_valid && known;
	assign cmd.op    = op;
	assign cmd.value = value;

endmodule

// ===== design/deq_cmdq.sv =====
// Short command queue between front and back end.
// Depends on deq_pkg for the command type and depth.
module deq_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  deq_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          pop_valid,
	output deq_pkg::cmd_t pop_cmd,
	input  logic          pop_take
);
	import deq_pkg::*;

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMDQ_DEPTH - 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(CMDQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_take && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/deq_back.sv =====
// Back end: ring store, front index and count, command sequencer, output register.
// Depends on deq_pkg; takes commands from deq_cmdq.
module deq_back #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  deq_pkg::cmd_t                     cmd,
	output logic                              cmd_take,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [deq_pkg::DATA_W-1:0] value_res,
	output logic                              last
);
	import deq_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
	                                          input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd_data_q;

	state_t            state_q, state_n;
	logic [IDX_W-1:0]  front_q, front_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_n;
	logic [CNT_W-1:0]  left_q, left_n;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic [1:0]        e_status;
	logic [DATA_W-1:0] e_value;
	logic              e_last;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              full;
	logic              empty;
	logic              push_ok;

	assign out_free = !out_valid_q || !out_stall;
	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;

	always_comb begin
		state_n  = state_q;
		front_n  = front_q;
		count_n  = count_q;
		rd_ptr_n = rd_ptr_q;
		left_n   = left_q;
		cmd_take = 1'b0;
		emit     = 1'b0;
		e_status = ST_OK;
		e_value  = '0;
		e_last   = 1'b1;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		push_ok  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_take = 1'b1;
					unique case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								push_ok = 1'b1;
								wr_en   = 1'b1;
								count_n = count_q + CNT_W'(1);
								if (cmd.op == OP_PUSH_FRONT) begin
									front_n = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
									wr_addr = front_n;
								end else begin
									wr_addr = ring(front_q, count_q);
								end
							end
						end
						OP_POP_FRONT, OP_POP_REAR, OP_DUMP: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								state_n = S_READ;
								left_n  = '0;
								if (cmd.op == OP_POP_FRONT) begin
									rd_addr = front_q;
									front_n = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
									count_n = count_q - CNT_W'(1);
								end else if (cmd.op == OP_POP_REAR) begin
									rd_addr = ring(front_q, count_q - CNT_W'(1));
									count_n = count_q - CNT_W'(1);
								end else begin
									rd_addr  = front_q;
									rd_ptr_n = front_q;
									left_n   = count_q - CNT_W'(1);
								end
							end
						end
						default: cmd_take = 1'b1;
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					emit    = 1'b1;
					e_value = rd_data_q;
					e_last  = left_q == '0;
					if (left_q != '0) begin
						// dump: fetch the next entry while this one goes out
						rd_en    = 1'b1;
						rd_ptr_n = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IDX_W'(1);
						rd_addr  = rd_ptr_n;
						left_n   = left_q - CNT_W'(1);
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			front_q  <= front_n;
			count_q  <= count_n;
			rd_ptr_q <= rd_ptr_n;
			left_q   <= left_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= e_status;
			out_value_q  <= e_value;
			out_last_q   <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value_res = out_value_q;
	assign last      = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("successful push did not bump the count");

	a_read_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> count_q == $past(count_q))
		else $error("count changed during a read");

	a_notlast_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> state_q == S_READ)
		else $error("non-final result outside a dump");

endmodule

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: front decoder, command queue, back end.
// Depends on deq_pkg, deq_front, deq_cmdq and deq_back.
//
// A bounded deque of signed 32-bit values in a ring of CAPACITY words.
// Each input transfer carries an action (push front/rear, pop front/rear, dump)
// and a value used only by pushes. A push returns one result, ok or full; a pop
// returns the removed value, or empty; a dump returns one result per entry from
// front to rear with last set on the rear entry, or a single empty result.
// Unused action codes are swallowed by the front end and give no result.
// Timing: the front end decodes in the transfer cycle and parks the command in a
// two-entry queue, so input is taken while the back end is busy or the output is
// stalled, until that queue fills. The back end runs one command at a time on
// the single-port ring memory: a push, or a command that fails on full or empty,
// emits its result directly; a pop first reads the memory into a register; a dump
// reads the next entry while the current one goes out. Results leave through one
// output register, which frees its slot in the cycle its transfer completes. The
// ring needs no clearing after reset; only live entries are ever read.
module double_ended_queue #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        action,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [deq_pkg::DATA_W-1:0] value_res,
	output logic                              last
);
	import deq_pkg::*;

	cmd_t fe_cmd;
	logic fe_valid;
	logic fe_ready;
	cmd_t be_cmd;
	logic be_valid;
	logic be_take;

	// decode and filter
	deq_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value     (value),
		.cmd_valid (fe_valid),
		.cmd       (fe_cmd),
		.cmd_ready (fe_ready)
	);

	// decouples input transfers from back-end progress
	deq_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_cmd   (fe_cmd),
		.push_ready (fe_ready),
		.pop_valid  (be_valid),
		.pop_cmd    (be_cmd),
		.pop_take   (be_take)
	);

	// ring store and result sequencing
	deq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (be_valid),
		.cmd       (be_cmd),
		.cmd_take  (be_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value_res (value_res),
		.last      (last)
	);

endmodule
